// ----- rtl/h2r_pkg.sv -----
`default_nettype none

package h2r_pkg;

    localparam int FRAC_BITS_DEFAULT = 8;

    localparam int NUM_STAGES = 9;
    localparam int HUE_STAGES = 5;

    localparam int DEG_FULL   = 360;
    localparam int DEG_SECTOR = 60;

    // 2^15 mod 360 is 8, so hue + 2^15 + 352 is congruent to hue mod 360
    localparam int HUE_OFFSET = 352;

    // floor(2^20 / 360); the quotient estimate is low by at most one
    localparam int RECIP       = 2912;
    localparam int RECIP_SHIFT = 20;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

endpackage

`default_nettype wire

// ----- rtl/h2r_hue_sector.sv -----
`default_nettype none

module h2r_hue_sector
(
    input  wire logic                                clk,
    input  wire logic signed [15:0]                  hue,
    input  wire logic [h2r_pkg::HUE_STAGES-1:0]      en,
    output h2r_pkg::sector_t                         sector,
    output logic [5:0]                               rem
);

    logic [16:0]      x_next;
    logic [16:0]      x0_reg;
    logic [28:0]      prod;
    logic [7:0]       q1_next;
    logic [7:0]       q1_reg;
    logic [16:0]      x1_reg;
    logic [16:0]      qm;
    logic [16:0]      diff;
    logic [9:0]       r2_reg;
    logic [8:0]       r3_next;
    logic [8:0]       r3_reg;
    h2r_pkg::sector_t sector_next;
    h2r_pkg::sector_t sector4_reg;
    logic [8:0]       base;
    logic [5:0]       rem_next;
    logic [5:0]       rem4_reg;

    assign x_next  = {1'b0, ~hue[15], hue[14:0]} + 17'(h2r_pkg::HUE_OFFSET);
    assign prod    = 29'(x0_reg) * 29'(h2r_pkg::RECIP);
    assign q1_next = prod[h2r_pkg::RECIP_SHIFT +: 8];
    assign qm      = {9'd0, q1_reg} * 17'(h2r_pkg::DEG_FULL);
    assign diff    = x1_reg - qm;
    assign r3_next = (r2_reg >= 10'(h2r_pkg::DEG_FULL))
                   ? 9'(r2_reg - 10'(h2r_pkg::DEG_FULL)) : r2_reg[8:0];

    always_comb
    begin
        if (r3_reg < 9'(h2r_pkg::DEG_SECTOR))
        begin
            sector_next = h2r_pkg::SECTOR_0;
            base        = 9'd0;
        end
        else if (r3_reg < 9'(2 * h2r_pkg::DEG_SECTOR))
        begin
            sector_next = h2r_pkg::SECTOR_1;
            base        = 9'(h2r_pkg::DEG_SECTOR);
        end
        else if (r3_reg < 9'(3 * h2r_pkg::DEG_SECTOR))
        begin
            sector_next = h2r_pkg::SECTOR_2;
            base        = 9'(2 * h2r_pkg::DEG_SECTOR);
        end
        else if (r3_reg < 9'(4 * h2r_pkg::DEG_SECTOR))
        begin
            sector_next = h2r_pkg::SECTOR_3;
            base        = 9'(3 * h2r_pkg::DEG_SECTOR);
        end
        else if (r3_reg < 9'(5 * h2r_pkg::DEG_SECTOR))
        begin
            sector_next = h2r_pkg::SECTOR_4;
            base        = 9'(4 * h2r_pkg::DEG_SECTOR);
        end
        else
        begin
            sector_next = h2r_pkg::SECTOR_5;
            base        = 9'(5 * h2r_pkg::DEG_SECTOR);
        end
        rem_next = 6'(r3_reg - base);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg <= x_next;
        end
        if (en[1])
        begin
            x1_reg <= x0_reg;
            q1_reg <= q1_next;
        end
        if (en[2])
        begin
            r2_reg <= diff[9:0];
        end
        if (en[3])
        begin
            r3_reg <= r3_next;
        end
        if (en[4])
        begin
            sector4_reg <= sector_next;
            rem4_reg    <= rem_next;
        end
    end

    assign sector = sector4_reg;
    assign rem    = rem4_reg;

endmodule

`default_nettype wire

// ----- rtl/hsv_to_rgb_converter.sv -----
// Each accepted input transaction yields its result on red/green/blue.
// Throughput: one transaction per cycle while out_stall is low, through a nine-stage pipeline
// with per-stage valid bits; a stalled output holds its stage and bubbles still close up behind it.
// Reset clears only the valid bits; data registers are not reset.
`default_nettype none

module hsv_to_rgb_converter
#(
    parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] hue,
    input  wire logic signed [9:0]  saturation,
    input  wire logic signed [9:0]  value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue
);

    localparam int NS        = h2r_pkg::NUM_STAGES;
    localparam int SW        = FRAC_BITS + 1;
    localparam int AW        = FRAC_BITS + 6;
    localparam int MQW       = 2 * FRAC_BITS + 7;
    localparam int MPW       = 2 * FRAC_BITS + 2;
    localparam int ONE_I     = 1 << FRAC_BITS;
    localparam int SIXTY_ONE = h2r_pkg::DEG_SECTOR * ONE_I;
    localparam int CQ_LO     = 2 * FRAC_BITS + 2;
    localparam int CP_LO     = 2 * FRAC_BITS;
    localparam int CV_LO     = FRAC_BITS;

    logic [NS:0]      stage_en;
    logic [NS-1:0]    valid_reg;
    logic [NS-1:0]    valid_next;

    logic [SW-1:0]    s_next;
    logic [SW-1:0]    v_next;
    logic [SW-1:0]    s_pipe_reg [0:4];
    logic [SW-1:0]    v_pipe_reg [0:6];

    h2r_pkg::sector_t sector4;
    logic [5:0]       rem4;
    h2r_pkg::sector_t sec5_reg;
    h2r_pkg::sector_t sec6_reg;
    h2r_pkg::sector_t sec7_reg;

    logic [AW-1:0]    aq_next;
    logic [AW-1:0]    at_next;
    logic [SW-1:0]    ap_next;
    logic [AW-1:0]    aq_reg;
    logic [AW-1:0]    at_reg;
    logic [SW-1:0]    ap_reg;

    logic [MQW-1:0]   mq_reg;
    logic [MQW-1:0]   mt_reg;
    logic [MPW-1:0]   mp_reg;

    logic [MQW+3:0]   q17;
    logic [MQW+3:0]   t17;
    logic [MPW+7:0]   p255;
    logic [SW+7:0]    v255;
    logic [7:0]       cq_reg;
    logic [7:0]       ct_reg;
    logic [7:0]       cp_reg;
    logic [7:0]       cv_reg;

    logic [7:0]       red_next;
    logic [7:0]       green_next;
    logic [7:0]       blue_next;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;

    always_comb
    begin
        stage_en[NS] = !out_stall;
        for (int i = NS - 1; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = stage_en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !stage_en[0];
    assign out_valid = valid_reg[NS-1];

    // clamp to 0..1.0
    always_comb
    begin
        if (saturation[9])
        begin
            s_next = '0;
        end
        else if (int'(saturation[8:0]) > ONE_I)
        begin
            s_next = SW'(ONE_I);
        end
        else
        begin
            s_next = SW'(saturation[8:0]);
        end

        if (value[9])
        begin
            v_next = '0;
        end
        else if (int'(value[8:0]) > ONE_I)
        begin
            v_next = SW'(ONE_I);
        end
        else
        begin
            v_next = SW'(value[8:0]);
        end
    end

    h2r_hue_sector u_hue_sector
    (
        .clk    (clk),
        .hue    (hue),
        .en     (stage_en[h2r_pkg::HUE_STAGES-1:0]),
        .sector (sector4),
        .rem    (rem4)
    );

    assign aq_next = AW'(SIXTY_ONE) - AW'(s_pipe_reg[4]) * AW'(rem4);
    assign at_next = AW'(SIXTY_ONE)
                   - AW'(s_pipe_reg[4]) * AW'(6'(h2r_pkg::DEG_SECTOR) - rem4);
    assign ap_next = SW'(ONE_I) - s_pipe_reg[4];

    // 255 / 60 = 17 / 4, so q and t scale by 17 and drop two more bits
    assign q17  = {mq_reg, 4'b0} + {4'b0, mq_reg};
    assign t17  = {mt_reg, 4'b0} + {4'b0, mt_reg};
    assign p255 = {mp_reg, 8'b0} - {8'b0, mp_reg};
    assign v255 = {v_pipe_reg[6], 8'b0} - {8'b0, v_pipe_reg[6]};

    always_comb
    begin
        case (sec7_reg)
            h2r_pkg::SECTOR_1:
            begin
                red_next = cq_reg; green_next = cv_reg; blue_next = cp_reg;
            end
            h2r_pkg::SECTOR_2:
            begin
                red_next = cp_reg; green_next = cv_reg; blue_next = ct_reg;
            end
            h2r_pkg::SECTOR_3:
            begin
                red_next = cp_reg; green_next = cq_reg; blue_next = cv_reg;
            end
            h2r_pkg::SECTOR_4:
            begin
                red_next = ct_reg; green_next = cp_reg; blue_next = cv_reg;
            end
            h2r_pkg::SECTOR_5:
            begin
                red_next = cv_reg; green_next = cp_reg; blue_next = cq_reg;
            end
            default:
            begin
                red_next = cv_reg; green_next = ct_reg; blue_next = cp_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            s_pipe_reg[0] <= s_next;
            v_pipe_reg[0] <= v_next;
        end
        for (int i = 1; i < 5; i++)
        begin
            if (stage_en[i])
            begin
                s_pipe_reg[i] <= s_pipe_reg[i-1];
            end
        end
        for (int i = 1; i < 7; i++)
        begin
            if (stage_en[i])
            begin
                v_pipe_reg[i] <= v_pipe_reg[i-1];
            end
        end
        if (stage_en[5])
        begin
            aq_reg   <= aq_next;
            at_reg   <= at_next;
            ap_reg   <= ap_next;
            sec5_reg <= sector4;
        end
        if (stage_en[6])
        begin
            mq_reg   <= MQW'(v_pipe_reg[5]) * MQW'(aq_reg);
            mt_reg   <= MQW'(v_pipe_reg[5]) * MQW'(at_reg);
            mp_reg   <= MPW'(v_pipe_reg[5]) * MPW'(ap_reg);
            sec6_reg <= sec5_reg;
        end
        if (stage_en[7])
        begin
            cq_reg   <= q17[CQ_LO +: 8];
            ct_reg   <= t17[CQ_LO +: 8];
            cp_reg   <= p255[CP_LO +: 8];
            cv_reg   <= v255[CV_LO +: 8];
            sec7_reg <= sec6_reg;
        end
        if (stage_en[8])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg))
    else $error("input stalled while the pipeline has a bubble");

    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without a transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_en[8] && valid_reg[7] && (cv_reg == 8'd0))
        |=> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("zero brightness produced a nonzero channel");

endmodule

`default_nettype wire
